/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Q24.8 signed raw words, operation codes and transfer payload structs.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 8;
  // dividend magnitude after the fraction shift
  localparam int NumBits  = WordBits + FracBits;
  localparam int StepsPerStage = 5;
  localparam int DivStages = NumBits / StepsPerStage;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_t;

  typedef struct packed {
    logic [3:0]                 operation;
    logic signed [WordBits-1:0] operand_a;
    logic signed [WordBits-1:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [WordBits-1:0] value;
    logic                       truth;
    logic                       saturated;
    logic                       divide_by_zero;
  } alu_out_t;

endpackage

/* rtl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed Q24.8 ALU
// Every operation passes through the same pipeline from start to strobe.
// Throughput: one operation per cycle; busy stays low, nothing stalls.
// The divider is a restoring array, five quotient bits per stage; the multiply
// is one 32x32 product registered before rounding.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fpa_pkg::alu_in_t  in_item,
  output logic              strobe,
  output fpa_pkg::alu_out_t result
);
  import fpa_pkg::*;

  localparam int L = DivStages + 3;
  localparam logic signed [WordBits:0] MaxW = {2'b00, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits:0] MinW = -MaxW - 1;
  localparam logic signed [WordBits:0] OneW = (WordBits+1)'(1);

  // ---------------- stage 0: decode, simple ops ----------------
  logic                       v0;
  op_t                        op0;
  logic signed [WordBits-1:0] a0, b0;
  alu_out_t                   simple0;
  logic signed [2*WordBits-1:0] prod0;
  logic [NumBits-1:0]         num0;
  logic [WordBits-1:0]        den0;
  logic                       neg0;

  function automatic logic signed [WordBits:0] sat33(input logic signed [WordBits:0] x,
                                                     output logic s);
    logic signed [WordBits:0] y;
    begin
      s = 1'b0;
      y = x;
      if (x > MaxW) begin y = MaxW; s = 1'b1; end
      if (x < MinW) begin y = MinW; s = 1'b1; end
      return y;
    end
  endfunction

  alu_out_t simple_c;
  always_comb begin
    logic signed [WordBits:0] ea, eb, t;
    logic s;
    op_t o;
    o = op_t'(in_item.operation);
    ea = {in_item.operand_a[WordBits-1], in_item.operand_a};
    eb = {in_item.operand_b[WordBits-1], in_item.operand_b};
    simple_c = '0;
    s = 1'b0;
    t = '0;
    case (o)
      OP_ADD: begin t = sat33(ea + eb, s); simple_c.value = t[WordBits-1:0]; end
      OP_SUB: begin t = sat33(ea - eb, s); simple_c.value = t[WordBits-1:0]; end
      OP_INC: begin t = sat33(ea + OneW, s); simple_c.value = t[WordBits-1:0]; end
      OP_DEC: begin t = sat33(ea - OneW, s); simple_c.value = t[WordBits-1:0]; end
      OP_GT: simple_c.truth = ea > eb;
      OP_LT: simple_c.truth = ea < eb;
      OP_GE: simple_c.truth = ea >= eb;
      OP_LE: simple_c.truth = ea <= eb;
      OP_EQ: simple_c.truth = ea == eb;
      OP_NE: simple_c.truth = ea != eb;
      OP_MIN: simple_c.value = (ea < eb) ? in_item.operand_a : in_item.operand_b;
      OP_MAX: simple_c.value = (ea > eb) ? in_item.operand_a : in_item.operand_b;
      OP_TO_INT: simple_c.value = in_item.operand_a >>> FracBits;
      OP_FROM_INT: begin
        // saturate when the bits shifted out are not all sign copies
        if (in_item.operand_a[WordBits-1:WordBits-1-FracBits] != '0 &&
            in_item.operand_a[WordBits-1:WordBits-1-FracBits] != '1) begin
          s = 1'b1;
          simple_c.value = in_item.operand_a[WordBits-1] ? MinW[WordBits-1:0]
                                                         : MaxW[WordBits-1:0];
        end else begin
          simple_c.value = in_item.operand_a <<< FracBits;
        end
      end
      default: ;
    endcase
    simple_c.saturated = s;
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    op0     <= op_t'(in_item.operation);
    a0      <= in_item.operand_a;
    b0      <= in_item.operand_b;
    simple0 <= simple_c;
  end
  assign busy = 1'b0;

  // ---------------- stage 1: product, divider operands ----------------
  logic                         v1;
  op_t                          op1;
  alu_out_t                     simple1;
  logic signed [2*WordBits-1:0] prod1;
  logic                         dz1;
  always_comb begin
    logic [WordBits-1:0] ma, mb;
    ma = a0[WordBits-1] ? WordBits'(-a0) : a0;
    mb = b0[WordBits-1] ? WordBits'(-b0) : b0;
    prod0 = a0 * b0;
    num0 = {ma, {FracBits{1'b0}}};
    den0 = mb;
    neg0 = a0[WordBits-1] ^ b0[WordBits-1];
  end

  // divider pipeline arrays
  logic [NumBits-1:0]  dq   [0:DivStages];
  logic [WordBits:0]   drem [0:DivStages];
  logic [WordBits-1:0] dden [0:DivStages];
  logic                dneg [0:DivStages];
  logic                dvld [0:DivStages];
  op_t                 dop  [0:DivStages];
  alu_out_t            dsim [0:DivStages];
  logic signed [2*WordBits-1:0] dprod [0:DivStages];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    op1     <= op0;
    simple1 <= simple0;
    prod1   <= prod0;
    dz1     <= (b0 == '0);
    dq[0]   <= num0;
    drem[0] <= '0;
    dden[0] <= den0;
    dneg[0] <= neg0;
  end
  assign dvld[0]  = v1;
  assign dop[0]   = op1;
  assign dprod[0] = prod1;
  always_comb begin
    dsim[0] = simple1;
    dsim[0].divide_by_zero = (op1 == OP_DIV) && dz1;
  end

  // restoring division, StepsPerStage quotient bits per stage; product and
  // simple results ride along
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [NumBits-1:0] q_c;
    logic [WordBits:0]  r_c;
    always_comb begin
      logic [WordBits+1:0] t;
      logic                nb;
      q_c = dq[s];
      r_c = drem[s];
      for (int k = 0; k < StepsPerStage; k++) begin
        // next numerator bit enters the partial remainder
        nb = q_c[NumBits-1];
        t = {r_c, nb} - {2'b00, dden[s]};
        q_c = {q_c[NumBits-2:0], ~t[WordBits+1]};
        if (!t[WordBits+1]) r_c = t[WordBits:0];
        else r_c = {r_c[WordBits-1:0], nb};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dvld[s+1] <= 1'b0;
      else dvld[s+1] <= dvld[s];
      dq[s+1]    <= q_c;
      drem[s+1]  <= r_c;
      dden[s+1]  <= dden[s];
      dneg[s+1]  <= dneg[s];
      dop[s+1]   <= dop[s];
      dsim[s+1]  <= dsim[s];
      dprod[s+1] <= dprod[s];
    end
  end

  // ---------------- final stage: rounding and saturation ----------------
  alu_out_t fin_c;
  always_comb begin
    logic [2*WordBits-1:0] pm;
    logic [2*WordBits-1:0] pr;
    logic [NumBits:0]      qr;
    logic [WordBits:0]     rr;
    logic signed [2*WordBits:0] sv;
    logic s;
    fin_c = dsim[DivStages];
    s = 1'b0;
    sv = '0;
    pm = '0;
    pr = '0;
    qr = '0;
    rr = '0;
    case (dop[DivStages])
      OP_MUL: begin
        pm = dprod[DivStages][2*WordBits-1] ? -dprod[DivStages] : dprod[DivStages];
        pr = (pm + (2*WordBits)'(1 << (FracBits-1))) >> FracBits;
        sv = dprod[DivStages][2*WordBits-1] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
      end
      OP_DIV: begin
        rr = drem[DivStages];
        qr = {1'b0, dq[DivStages]};
        if ((rr << 1) >= {1'b0, dden[DivStages]}) qr = qr + 1'b1;
        sv = dneg[DivStages] ? -$signed({{(WordBits-FracBits){1'b0}}, qr})
                             : $signed({{(WordBits-FracBits){1'b0}}, qr});
      end
      default: ;
    endcase
    if (dop[DivStages] == OP_MUL ||
        (dop[DivStages] == OP_DIV && !dsim[DivStages].divide_by_zero)) begin
      if (sv > $signed((2*WordBits+1)'(MaxW))) begin
        sv = (2*WordBits+1)'(MaxW); s = 1'b1;
      end else if (sv < $signed({{WordBits{1'b1}}, MinW})) begin
        sv = {{WordBits{1'b1}}, MinW}; s = 1'b1;
      end
      fin_c.value = sv[WordBits-1:0];
      fin_c.saturated = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= dvld[DivStages];
    result <= fin_c;
  end

  // ---------------- checks ----------------
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start ##L 1'b1 |-> strobe) else $error("lost item");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(result.truth && result.saturated)) else $error("flag mix");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    strobe && result.divide_by_zero |-> result.value == '0) else $error("dz value");

endmodule
